FILE: src/dlt_pkg.sv
// Shared constants and types of the line tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package dlt_pkg;

  localparam int MAX_WORDS = 32;
  localparam int MAX_LINE  = 256;

  localparam int WF_W      = $clog2(MAX_WORDS + 1);
  localparam int CS_W      = $clog2(MAX_LINE + 2);
  localparam int DEPTH_W   = 9;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  localparam int CHAR_W    = 8;
  localparam int KIND_W    = 2;
  localparam int IDX_W     = 5;
  localparam int CNT_W     = 6;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic [PADDR_W-3:0] REG_APPLE_QUOTE = '0;

  localparam logic [KIND_W-1:0] KIND_CHAR     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WORD_END = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LINE_END = 2'd2;

  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3a;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] out_char;
    logic [IDX_W-1:0]  word_index;
    logic [CNT_W-1:0]  word_count;
    logic              too_long;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } step_t;

endpackage
`default_nettype wire

FILE: src/dsc_line_tokenizer.sv
// Top level of the line tokenizer: channels, register port and result queue.
//
// Input channel: one beat per line character (ch_i), or an end-of-line beat
// (end_of_line_i high, ch_i ignored). A beat is taken when in_valid_i is high
// and in_stall_o is low.
// Output channel: one beat per result (kind_o, out_char_o, word_index_o,
// word_count_o, too_long_o, last_o); last_o marks the final result of an
// input beat. A beat leaves when out_valid_o is high and out_stall_i is low.
// Results of a beat are written into the result queue when the beat is taken.
// Throughput: one input beat per cycle while in_stall_o is low; a beat yielding
// two results (word end at a colon or at end of line) takes two queue entries.
// The four-entry result queue sets this: in_stall_o rises while it holds more
// than two results, and a stalled receiver fills it and then stalls the input.
// Register 0 at byte address 0 (APB write, pready always high) holds the
// double-quote enable. Write it only while the block is idle (unenforced).
// Reset clears the line state, the queue and the register at once.
`timescale 1ns / 1ps
`default_nettype none
module dsc_line_tokenizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dlt_pkg::PADDR_W-1:0]   paddr,
  input  logic [dlt_pkg::PDATA_W-1:0]   pwdata,
  output logic [dlt_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dlt_pkg::CHAR_W-1:0]    ch_i,
  input  logic                          end_of_line_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dlt_pkg::KIND_W-1:0]    kind_o,
  output logic [dlt_pkg::CHAR_W-1:0]    out_char_o,
  output logic [dlt_pkg::IDX_W-1:0]     word_index_o,
  output logic [dlt_pkg::CNT_W-1:0]     word_count_o,
  output logic                          too_long_o,
  output logic                          last_o
);
  import dlt_pkg::*;

  logic     apple_q;
  logic     reg_hit;
  logic     accept;
  logic     room;
  step_t    step;
  result_t  head;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_APPLE_QUOTE);
  assign prdata  = reg_hit ? PDATA_W'(apple_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apple_q <= 1'b0;
    end else if (psel && penable && pwrite && reg_hit) begin
      apple_q <= pwdata[0];
    end
  end

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  dlt_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .ch_i          (ch_i),
    .end_of_line_i (end_of_line_i),
    .apple_quote_i (apple_q),
    .step_o        (step)
  );

  dlt_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .step_i  (step),
    .pop_i   (!out_stall_i),
    .room_o  (room),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign kind_o       = head.kind;
  assign out_char_o   = head.out_char;
  assign word_index_o = head.word_index;
  assign word_count_o = head.word_count;
  assign too_long_o   = head.too_long;
  assign last_o       = head.last;

endmodule
`default_nettype wire

FILE: src/dlt_core.sv
// Per-character tokenizing logic and line state of the tokenizer.
`timescale 1ns / 1ps
`default_nettype none
module dlt_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [dlt_pkg::CHAR_W-1:0]   ch_i,
  input  logic                         end_of_line_i,
  input  logic                         apple_quote_i,
  output dlt_pkg::step_t               step_o
);
  import dlt_pkg::*;

  typedef enum logic [1:0] {PH_START, PH_WORD, PH_SKIP, PH_DONE} phase_e;

  phase_e              phase_q, phase_d;
  logic [DEPTH_W-1:0]  paren_q, paren_d;
  logic [DEPTH_W-1:0]  dquote_q, dquote_d;
  logic                whc_q, whc_d;
  logic [CHAR_W-1:0]   prev_q, prev_d;
  logic [WF_W-1:0]     words_q, words_d;
  logic [CS_W-1:0]     chars_q, chars_d;

  logic                ws;
  logic                drop;
  logic                too_long;
  logic [IDX_W-1:0]    idx;
  result_t             res_char, res_wend, res_lend;
  step_t               step;

  always_comb begin
    ws       = (ch_i == CH_SPACE) || (ch_i == CH_TAB);
    too_long = (chars_q > CS_W'(MAX_LINE));
    phase_d  = phase_q;
    paren_d  = paren_q;
    dquote_d = dquote_q;
    whc_d    = whc_q;
    prev_d   = prev_q;
    words_d  = words_q;
    chars_d  = chars_q;
    drop     = 1'b0;
    step     = '0;

    res_lend            = '0;
    res_lend.kind       = KIND_LINE_END;
    res_lend.word_count = CNT_W'(words_q);
    res_lend.too_long   = too_long;
    res_lend.last       = 1'b1;

    if (end_of_line_i) begin
      idx           = IDX_W'(words_q - WF_W'(1));
      res_wend      = '0;
      res_wend.kind = KIND_WORD_END;
      res_wend.word_index = idx;
      res_char      = '0;
      if (phase_q == PH_WORD) begin
        step.n  = 2'd2;
        step.r0 = res_wend;
        step.r1 = res_lend;
      end else begin
        step.n  = 2'd1;
        step.r0 = res_lend;
      end
      phase_d  = PH_START;
      paren_d  = '0;
      dquote_d = '0;
      whc_d    = 1'b0;
      prev_d   = '0;
      words_d  = '0;
      chars_d  = '0;
    end else begin
      if (chars_q <= CS_W'(MAX_LINE)) begin
        chars_d = chars_q + CS_W'(1);
      end
      if (phase_q != PH_WORD) begin
        words_d = words_q + WF_W'(1);
        whc_d   = 1'b0;
        prev_d  = '0;
      end
      idx                 = IDX_W'(words_d - WF_W'(1));
      res_wend            = '0;
      res_wend.kind       = KIND_WORD_END;
      res_wend.word_index = idx;
      res_char            = '0;
      res_char.kind       = KIND_CHAR;
      res_char.out_char   = ch_i;
      res_char.word_index = idx;

      if ((phase_q == PH_DONE) || ((phase_q == PH_SKIP) && ws)) begin
        words_d = words_q;
        whc_d   = whc_q;
        prev_d  = prev_q;
      end else begin
        phase_d = PH_WORD;
        if (ws && (paren_q == '0) && (dquote_q == '0)) begin
          res_wend.last = 1'b1;
          step.n  = 2'd1;
          step.r0 = res_wend;
          whc_d   = 1'b0;
          prev_d  = '0;
          phase_d = (words_d >= WF_W'(MAX_WORDS)) ? PH_DONE : PH_SKIP;
        end else begin
          if (!whc_d && (ch_i == CH_LPAREN) && (prev_d != CH_BSLASH)) begin
            if (paren_q < DEPTH_MAX) begin
              paren_d = paren_q + DEPTH_W'(1);
            end
            drop = (paren_d == DEPTH_W'(1));
          end else if ((paren_q != '0) && (ch_i == CH_RPAREN) && (prev_d != CH_BSLASH)) begin
            paren_d = paren_q - DEPTH_W'(1);
            drop    = (paren_d == '0);
          end else if (apple_quote_i && (paren_q == '0) && (ch_i == CH_DQUOTE)) begin
            if (!whc_d) begin
              if (dquote_q < DEPTH_MAX) begin
                dquote_d = dquote_q + DEPTH_W'(1);
              end
              drop = 1'b1;
            end else if (dquote_q != '0) begin
              dquote_d = dquote_q - DEPTH_W'(1);
              drop     = 1'b1;
            end
          end
          if (!drop) begin
            prev_d = ch_i;
            whc_d  = 1'b1;
            if ((words_d == WF_W'(1)) && (ch_i == CH_COLON)) begin
              res_wend.last = 1'b1;
              step.n  = 2'd2;
              step.r0 = res_char;
              step.r1 = res_wend;
              whc_d   = 1'b0;
              prev_d  = '0;
              phase_d = (words_d >= WF_W'(MAX_WORDS)) ? PH_DONE : PH_SKIP;
            end else begin
              res_char.last = 1'b1;
              step.n  = 2'd1;
              step.r0 = res_char;
            end
          end
        end
      end
    end
  end

  assign step_o = step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      paren_q  <= '0;
      dquote_q <= '0;
      whc_q    <= 1'b0;
      prev_q   <= '0;
      words_q  <= '0;
      chars_q  <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      paren_q  <= paren_d;
      dquote_q <= dquote_d;
      whc_q    <= whc_d;
      prev_q   <= prev_d;
      words_q  <= words_d;
      chars_q  <= chars_d;
    end
  end

`ifndef SYNTH
  a_words_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    words_q <= WF_W'(MAX_WORDS))
    else $error("word count beyond limit");
  a_done_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |-> (words_q == WF_W'(MAX_WORDS)))
    else $error("word limit state without full word count");
  a_start_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_START) |-> (words_q == '0))
    else $error("line start with words pending");
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (step.n == 2'd2)) |-> (step.r1.last && !step.r0.last))
    else $error("two-beat item with bad last marking");
`endif

endmodule
`default_nettype wire

FILE: src/dlt_outq.sv
// Four-entry result queue between the tokenizer logic and the output channel.
`timescale 1ns / 1ps
`default_nettype none
module dlt_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dlt_pkg::step_t  step_i,
  input  logic            pop_i,
  output logic            room_o,
  output logic            valid_o,
  output dlt_pkg::result_t head_o
);
  import dlt_pkg::*;

  localparam int QD   = 4;
  localparam int QA_W = $clog2(QD);
  localparam int QC_W = $clog2(QD + 1);

  result_t          mem_q [QD];
  logic [QA_W-1:0]  wr_q, rd_q;
  logic [QC_W-1:0]  count_q;
  logic [1:0]       push_n;
  logic             pop;

  assign push_n  = push_i ? step_i.n : 2'd0;
  assign valid_o = (count_q != '0);
  assign pop     = pop_i && valid_o;
  assign head_o  = mem_q[rd_q];
  assign room_o  = (count_q <= QC_W'(QD - 2));

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_q] <= step_i.r0;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_q + QA_W'(1)] <= step_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + QA_W'(push_n);
      rd_q    <= rd_q + QA_W'(pop);
      count_q <= count_q + QC_W'(push_n) - QC_W'(pop);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QC_W'(QD))
    else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0) |-> room_o)
    else $error("push without room for two beats");
`endif

endmodule
`default_nettype wire

FILE: bench/dlt_token_checker.sv
// Checker for the line tokenizer: watches both channels and the register port, predicts and compares.
`timescale 1ns / 1ps
module dlt_token_checker
  import dlt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  input  logic                pready,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [CHAR_W-1:0]   ch_i,
  input  logic                end_of_line_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [CHAR_W-1:0]   out_char_i,
  input  logic [IDX_W-1:0]    word_index_i,
  input  logic [CNT_W-1:0]    word_count_i,
  input  logic                too_long_i,
  input  logic                last_i,
  output int                  pending_o,
  output int                  fail_count_o
);

  typedef enum logic [1:0] {
    PH_START,
    PH_WORD,
    PH_SKIP,
    PH_FULL
  } line_phase_e;

  result_t            expected_results[$];
  result_t            beat_results[2];
  int                 beat_count;
  int                 mismatch_count;

  bit                 dquote_en;
  line_phase_e        line_phase;
  logic [DEPTH_W-1:0] paren_depth;
  logic [DEPTH_W-1:0] dquote_depth;
  bit                 word_has_chars;
  logic [CHAR_W-1:0]  prev_kept;
  int                 words_found;
  int                 chars_seen;

  function automatic void clear_line();
    line_phase     = PH_START;
    paren_depth    = '0;
    dquote_depth   = '0;
    word_has_chars = 1'b0;
    prev_kept      = '0;
    words_found    = 0;
    chars_seen     = 0;
  endfunction

  function automatic void add_result(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] c, int idx,
                                     int cnt, bit tl);
    result_t r;
    r.kind       = kind;
    r.out_char   = c;
    r.word_index = IDX_W'(idx);
    r.word_count = CNT_W'(cnt);
    r.too_long   = tl;
    r.last       = 1'b0;
    beat_results[beat_count] = r;
    beat_count++;
  endfunction

  function automatic void close_word();
    add_result(KIND_WORD_END, '0, words_found - 1, 0, 1'b0);
    word_has_chars = 1'b0;
    prev_kept      = '0;
    line_phase     = (words_found >= MAX_WORDS) ? PH_FULL : PH_SKIP;
  endfunction

  function automatic void tokenize_beat(logic [CHAR_W-1:0] c, logic eol);
    bit ws;
    bit drop;
    ws = (c == CH_SPACE) || (c == CH_TAB);
    beat_count = 0;
    if (eol) begin
      if (line_phase == PH_WORD) close_word();
      add_result(KIND_LINE_END, '0, 0, words_found, chars_seen > MAX_LINE);
      clear_line();
    end else begin
      if (chars_seen <= MAX_LINE) chars_seen++;
      if (!(line_phase == PH_FULL || (line_phase == PH_SKIP && ws))) begin
        if (line_phase != PH_WORD) begin
          words_found++;
          line_phase     = PH_WORD;
          word_has_chars = 1'b0;
          prev_kept      = '0;
        end
        if (ws && paren_depth == 0 && dquote_depth == 0) begin
          close_word();
        end else begin
          drop = 1'b0;
          if (!word_has_chars && c == CH_LPAREN && prev_kept != CH_BSLASH) begin
            if (paren_depth != DEPTH_MAX) paren_depth++;
            drop = (paren_depth == 1);
          end else if (paren_depth != 0 && c == CH_RPAREN && prev_kept != CH_BSLASH) begin
            paren_depth--;
            drop = (paren_depth == 0);
          end else if (dquote_en && paren_depth == 0 && c == CH_DQUOTE) begin
            if (!word_has_chars) begin
              if (dquote_depth != DEPTH_MAX) dquote_depth++;
              drop = 1'b1;
            end else if (dquote_depth != 0) begin
              dquote_depth--;
              drop = 1'b1;
            end
          end
          if (!drop) begin
            add_result(KIND_CHAR, c, words_found - 1, 0, 1'b0);
            prev_kept      = c;
            word_has_chars = 1'b1;
            if (words_found == 1 && c == CH_COLON) close_word();
          end
        end
      end
    end
    if (beat_count > 0) beat_results[beat_count-1].last = 1'b1;
    for (int i = 0; i < beat_count; i++) expected_results.push_back(beat_results[i]);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      dquote_en      = 1'b0;
      mismatch_count = 0;
      clear_line();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("kind: expected no beat, got %0d", kind_i);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_i));
          check_field("out_char", 32'(want.out_char), 32'(out_char_i));
          check_field("word_index", 32'(want.word_index), 32'(word_index_i));
          check_field("word_count", 32'(want.word_count), 32'(word_count_i));
          check_field("too_long", 32'(want.too_long), 32'(too_long_i));
          check_field("last", 32'(want.last), 32'(last_i));
        end
      end
      if (in_valid_i && !in_stall_i) tokenize_beat(ch_i, end_of_line_i);
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_APPLE_QUOTE) begin
        dquote_en = pwdata[0];
      end
      pending_o    <= expected_results.size();
      fail_count_o <= mismatch_count;
    end
  end

endmodule

FILE: bench/dsc_line_tokenizer_test.sv
// Testbench top for the line tokenizer: clock, reset, line stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module dsc_line_tokenizer_test;
  import dlt_pkg::*;

  localparam int LONG_HOLD = 200;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [PADDR_W-1:0]  paddr         = '0;
  logic [PDATA_W-1:0]  pwdata        = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [CHAR_W-1:0]   ch_i          = '0;
  logic                end_of_line_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [KIND_W-1:0]   kind_o;
  logic [CHAR_W-1:0]   out_char_o;
  logic [IDX_W-1:0]    word_index_o;
  logic [CNT_W-1:0]    word_count_o;
  logic                too_long_o;
  logic                last_o;

  int                  pending;
  int                  fail_count;
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  bit                  hold_request   = 1'b0;
  bit                  hold_served    = 1'b0;
  logic [CHAR_W-1:0]   line_buf[$];

  dsc_line_tokenizer u_top (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .ch_i, .end_of_line_i,
    .out_valid_o, .out_stall_i, .kind_o, .out_char_o, .word_index_o, .word_count_o,
    .too_long_o, .last_o
  );

  dlt_token_checker u_checker (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_i(in_stall_o), .ch_i, .end_of_line_i,
    .out_valid_i(out_valid_o), .out_stall_i, .kind_i(kind_o), .out_char_i(out_char_o),
    .word_index_i(word_index_o), .word_count_i(word_count_o), .too_long_i(too_long_o),
    .last_i(last_o),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Hold off the receiver once for a long stretch, else stall at random.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [PADDR_W-3:0] idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_dquote(input bit en);
    write_reg(REG_APPLE_QUOTE, {31'($urandom_range(32'h7fff_ffff)), en});
  endtask

  task automatic send_beat(input logic [CHAR_W-1:0] c, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    ch_i          <= c;
    end_of_line_i <= eol;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_line_buf();
    foreach (line_buf[i]) send_beat(line_buf[i], 1'b0);
    send_beat(CHAR_W'($urandom_range(255)), 1'b1);
    line_buf.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line_buf();
  endtask

  // Drop valid, wait out every expected beat, then let trailing work settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [CHAR_W-1:0] ws_char();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [CHAR_W-1:0] any_char();
    int r;
    r = $urandom_range(99);
    if (r < 8) return CH_SPACE;
    else if (r < 12) return CH_TAB;
    else if (r < 18) return CH_LPAREN;
    else if (r < 24) return CH_RPAREN;
    else if (r < 29) return CH_BSLASH;
    else if (r < 33) return CH_COLON;
    else if (r < 39) return CH_DQUOTE;
    else if (r < 75) return CHAR_W'("a" + $urandom_range(25));
    else return CHAR_W'($urandom_range(255));
  endfunction

  function automatic void build_random_line();
    int nwords;
    int opener;
    line_buf.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(12)) line_buf.push_back(any_char());
      return;
    end
    if ($urandom_range(4) == 0) line_buf.push_back(ws_char());
    nwords = $urandom_range(6);
    for (int w = 0; w < nwords; w++) begin
      opener = $urandom_range(5);
      if (opener == 0) line_buf.push_back(CH_LPAREN);
      else if (opener == 1) line_buf.push_back(CH_DQUOTE);
      repeat ($urandom_range(1, 5)) line_buf.push_back(any_char());
      if (w == 0 && $urandom_range(2) == 0) line_buf.push_back(CH_COLON);
      if (opener < 2 && $urandom_range(4) != 0) begin
        if ($urandom_range(7) == 0) line_buf.push_back(CH_BSLASH);
        line_buf.push_back(opener == 0 ? CH_RPAREN : CH_DQUOTE);
      end
      repeat ($urandom_range(1, 2)) line_buf.push_back(ws_char());
    end
  endfunction

  initial begin
    int idle_pct[4];
    int stall_pct[4];
    int phase_items;
    idle_pct  = '{0, 72, 0, 17};
    stall_pct = '{0, 0, 72, 17};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_dquote(1'b0);
    send_line_buf();
    send_text("\tx");
    send_text("k:(a b)");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hff);
    send_line_buf();
    send_text("(\\)x)");
    drain();
    set_dquote(1'b1);
    send_text("\"a b\"");
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pct[p];
      recv_stall_pct <= stall_pct[p];
      set_dquote(p % 2 == 0);
      if (p == 0) hold_request <= 1'b1;
      phase_items = 0;
      while (phase_items < 50) begin
        build_random_line();
        phase_items += line_buf.size() + 1;
        send_line_buf();
      end
      if (p == 0) begin
        repeat (258) line_buf.push_back(CH_DQUOTE);
        line_buf.push_back("a");
        line_buf.push_back(CH_DQUOTE);
        send_line_buf();
      end
      if (p == 1) begin
        repeat (36) begin
          repeat ($urandom_range(1, 2)) line_buf.push_back(CHAR_W'("a" + $urandom_range(25)));
          line_buf.push_back(ws_char());
        end
        send_line_buf();
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
